// File: sv/e2c_pkg.sv
// Shared constants, payload types and arithmetic helpers for the
// equirectangular to cubemap lookup pipeline. No dependencies.
package e2c_pkg;

  localparam int MAX_HEIGHT = 2048;
  localparam int FRAC_BITS  = 17;
  localparam int ANG_BITS   = 20;

  localparam int H_W    = 12;
  localparam int ROW_W  = 11;
  localparam int COL_W  = 12;
  localparam int FACE_W = 3;

  localparam logic [H_W-1:0] H_RESET = H_W'(1024);
  localparam logic [H_W-1:0] H_MIN   = H_W'(2);
  localparam logic [H_W-1:0] H_MAX   = H_W'(MAX_HEIGHT);

  // angle divider: numerator is col (or row) shifted up by ANG_BITS
  localparam int ANG_NUM_W     = COL_W + ANG_BITS;
  localparam int DVS_W         = $clog2(2 * MAX_HEIGHT);
  localparam int ANG_PER_STAGE = 2;
  localparam int ANG_STAGES    = ANG_NUM_W / ANG_PER_STAGE;

  // cordic
  localparam int CORDIC_ITERS     = 20;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_STAGES    = CORDIC_ITERS / CORDIC_PER_STAGE;
  localparam int TRIG_W           = FRAC_BITS + 3;
  localparam int Z_W              = ANG_BITS + 1;
  localparam longint GAIN_Q30     = 652032874;
  localparam logic signed [TRIG_W-1:0] CORDIC_K = TRIG_W'(GAIN_Q30 >> (30 - FRAC_BITS));

  // component magnitudes and face ratio
  localparam int MAG_W  = TRIG_W;
  localparam int PROD_W = 2 * MAG_W;
  localparam int AX_W   = PROD_W - FRAC_BITS;
  localparam int AB_W   = AX_W + 1;
  localparam int SAB_W  = AB_W + 1;
  localparam int NUM_W  = H_W + AB_W;
  localparam int DEN_W  = AX_W + 1;
  localparam int Q_W    = H_W;
  localparam int REM_W  = NUM_W - Q_W;
  localparam int RAT_PER_STAGE = 2;
  localparam int RAT_STAGES    = Q_W / RAT_PER_STAGE;

  localparam logic [FACE_W-1:0] FACE_XP = FACE_W'(0);
  localparam logic [FACE_W-1:0] FACE_XN = FACE_W'(1);
  localparam logic [FACE_W-1:0] FACE_YP = FACE_W'(2);
  localparam logic [FACE_W-1:0] FACE_YN = FACE_W'(3);
  localparam logic [FACE_W-1:0] FACE_ZP = FACE_W'(4);
  localparam logic [FACE_W-1:0] FACE_ZN = FACE_W'(5);

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_e;

  typedef struct packed {
    logic [H_W-1:0]      h;
    logic [ANG_BITS-1:0] t;
    logic [ANG_BITS-1:0] p;
  } ang_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [Z_W-1:0]    z;
  } cvec_t;

  typedef struct packed {
    logic [H_W-1:0]           h;
    logic signed [TRIG_W-1:0] st;
    logic signed [TRIG_W-1:0] ct;
    logic signed [TRIG_W-1:0] sp;
    logic signed [TRIG_W-1:0] cp;
  } trig_t;

  typedef struct packed {
    logic [H_W-1:0]    h;
    logic [FACE_W-1:0] face;
    logic              zero;
    logic [NUM_W-1:0]  nx;
    logic [NUM_W-1:0]  ny;
    logic [DEN_W-1:0]  den;
  } ratio_t;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [H_W-1:0]    fx;
    logic [H_W-1:0]    fy;
  } res_t;

  // arctangent of 2^-i in 2^-20 turn units
  function automatic logic signed [Z_W-1:0] atan_turn(int i);
    case (i)
      0:       return Z_W'(131072);
      1:       return Z_W'(77376);
      2:       return Z_W'(40884);
      3:       return Z_W'(20753);
      4:       return Z_W'(10417);
      5:       return Z_W'(5213);
      6:       return Z_W'(2607);
      7:       return Z_W'(1304);
      8:       return Z_W'(652);
      9:       return Z_W'(326);
      10:      return Z_W'(163);
      11:      return Z_W'(81);
      12:      return Z_W'(41);
      13:      return Z_W'(20);
      14:      return Z_W'(10);
      15:      return Z_W'(5);
      16:      return Z_W'(3);
      17:      return Z_W'(1);
      18:      return Z_W'(1);
      default: return Z_W'(0);
    endcase
  endfunction

  function automatic cvec_t cordic_iter(cvec_t v, int i);
    cvec_t r;
    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    dx = v.y >>> i;
    dy = v.x >>> i;
    if (!v.z[Z_W-1]) begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - atan_turn(i);
    end else begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + atan_turn(i);
    end
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] mag(logic signed [TRIG_W-1:0] v);
    return v[TRIG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

endpackage

// File: sv/e2c_angle_div.sv
// Pipelined restoring divider that turns column and row into 20-bit turn
// fractions, two quotient bits per stage. Depends on e2c_pkg.
module e2c_angle_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [e2c_pkg::H_W-1:0]       h_i,
  input  logic [e2c_pkg::ROW_W-1:0]     row_i,
  input  logic [e2c_pkg::COL_W-1:0]     col_i,
  output logic                          valid_o,
  output e2c_pkg::ang_t                 ang_o
);

  typedef struct packed {
    logic [e2c_pkg::H_W-1:0]       h;
    logic [e2c_pkg::DVS_W-1:0]     dt;
    logic [e2c_pkg::DVS_W-1:0]     dp;
    logic [e2c_pkg::ANG_NUM_W-1:0] nt;
    logic [e2c_pkg::ANG_NUM_W-1:0] np;
    logic [e2c_pkg::DVS_W-1:0]     rt;
    logic [e2c_pkg::DVS_W-1:0]     rp;
    logic [e2c_pkg::ANG_BITS-1:0]  qt;
    logic [e2c_pkg::ANG_BITS-1:0]  qp;
  } dstage_t;

  dstage_t                         seed;
  dstage_t                         st_q [0:e2c_pkg::ANG_STAGES];
  dstage_t                         st_d [1:e2c_pkg::ANG_STAGES];
  logic [e2c_pkg::ANG_STAGES:0]    v_q;

  // returns {quotient bit, new remainder}
  function automatic logic [e2c_pkg::DVS_W:0] div_step(
    logic [e2c_pkg::DVS_W-1:0] r, logic [e2c_pkg::DVS_W-1:0] d, logic b);
    logic [e2c_pkg::DVS_W:0] sh;
    sh = {r, b};
    if (sh >= {1'b0, d}) begin
      return {1'b1, e2c_pkg::DVS_W'(sh - {1'b0, d})};
    end
    return {1'b0, sh[e2c_pkg::DVS_W-1:0]};
  endfunction

  always_comb begin
    logic [e2c_pkg::DVS_W:0] two_h;
    two_h     = (e2c_pkg::DVS_W + 1)'(h_i) << 1;
    seed.h    = h_i;
    seed.dt   = e2c_pkg::DVS_W'(two_h - 1'b1);
    seed.dp   = e2c_pkg::DVS_W'(two_h - 2'd2);
    seed.nt   = e2c_pkg::ANG_NUM_W'(col_i) << e2c_pkg::ANG_BITS;
    seed.np   = e2c_pkg::ANG_NUM_W'(row_i) << e2c_pkg::ANG_BITS;
    seed.rt   = '0;
    seed.rp   = '0;
    seed.qt   = '0;
    seed.qp   = '0;
  end

  always_comb begin
    logic [e2c_pkg::DVS_W:0] rt_s;
    logic [e2c_pkg::DVS_W:0] rp_s;
    int                      k;
    for (int s = 1; s <= e2c_pkg::ANG_STAGES; s++) begin
      st_d[s] = st_q[s-1];
      for (int j = 0; j < e2c_pkg::ANG_PER_STAGE; j++) begin
        k    = e2c_pkg::ANG_NUM_W - 1 - ((s - 1) * e2c_pkg::ANG_PER_STAGE + j);
        rt_s = div_step(st_d[s].rt, st_d[s].dt, st_d[s].nt[k]);
        rp_s = div_step(st_d[s].rp, st_d[s].dp, st_d[s].np[k]);
        st_d[s].rt = rt_s[e2c_pkg::DVS_W-1:0];
        st_d[s].rp = rp_s[e2c_pkg::DVS_W-1:0];
        // only the low ANG_BITS of the quotient matter: angle wraps per turn
        st_d[s].qt = {st_d[s].qt[e2c_pkg::ANG_BITS-2:0], rt_s[e2c_pkg::DVS_W]};
        st_d[s].qp = {st_d[s].qp[e2c_pkg::ANG_BITS-2:0], rp_s[e2c_pkg::DVS_W]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[e2c_pkg::ANG_STAGES-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= seed;
      for (int s = 1; s <= e2c_pkg::ANG_STAGES; s++) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign valid_o = v_q[e2c_pkg::ANG_STAGES];
  assign ang_o.h = st_q[e2c_pkg::ANG_STAGES].h;
  assign ang_o.t = st_q[e2c_pkg::ANG_STAGES].qt;
  assign ang_o.p = st_q[e2c_pkg::ANG_STAGES].qp;

endmodule

// File: sv/e2c_cordic.sv
// Two-lane pipelined rotation CORDIC giving sin and cos of both angles,
// followed by the quadrant fold-out stage. Depends on e2c_pkg.
module e2c_cordic (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  e2c_pkg::ang_t  ang_i,
  output logic           valid_o,
  output e2c_pkg::trig_t trig_o
);

  typedef struct packed {
    logic [e2c_pkg::H_W-1:0] h;
    logic [1:0]              qt;
    logic [1:0]              qp;
    e2c_pkg::cvec_t          vt;
    e2c_pkg::cvec_t          vp;
  } cstage_t;

  cstage_t                         seed;
  cstage_t                         st_q [0:e2c_pkg::CORDIC_STAGES];
  cstage_t                         st_d [1:e2c_pkg::CORDIC_STAGES];
  logic [e2c_pkg::CORDIC_STAGES:0] v_q;
  e2c_pkg::trig_t                  trig_d;
  e2c_pkg::trig_t                  trig_q;
  logic                            vm_q;

  // returns {sin, cos}
  function automatic logic [2*e2c_pkg::TRIG_W-1:0] fold(e2c_pkg::cvec_t v,
                                                        logic [1:0] q);
    case (e2c_pkg::quad_e'(q))
      e2c_pkg::QUAD_I:   return {v.y, v.x};
      e2c_pkg::QUAD_II:  return {v.x, -v.y};
      e2c_pkg::QUAD_III: return {-v.y, -v.x};
      e2c_pkg::QUAD_IV:  return {-v.x, v.y};
      default:           return {v.y, v.x};
    endcase
  endfunction

  always_comb begin
    seed.h    = ang_i.h;
    seed.qt   = ang_i.t[e2c_pkg::ANG_BITS-1 -: 2];
    seed.qp   = ang_i.p[e2c_pkg::ANG_BITS-1 -: 2];
    seed.vt.x = e2c_pkg::CORDIC_K;
    seed.vt.y = '0;
    seed.vt.z = e2c_pkg::Z_W'(ang_i.t[e2c_pkg::ANG_BITS-3:0]);
    seed.vp.x = e2c_pkg::CORDIC_K;
    seed.vp.y = '0;
    seed.vp.z = e2c_pkg::Z_W'(ang_i.p[e2c_pkg::ANG_BITS-3:0]);
  end

  always_comb begin
    for (int s = 1; s <= e2c_pkg::CORDIC_STAGES; s++) begin
      st_d[s] = st_q[s-1];
      for (int j = 0; j < e2c_pkg::CORDIC_PER_STAGE; j++) begin
        st_d[s].vt = e2c_pkg::cordic_iter(st_d[s].vt,
                                          (s - 1) * e2c_pkg::CORDIC_PER_STAGE + j);
        st_d[s].vp = e2c_pkg::cordic_iter(st_d[s].vp,
                                          (s - 1) * e2c_pkg::CORDIC_PER_STAGE + j);
      end
    end
  end

  always_comb begin
    trig_d.h                = st_q[e2c_pkg::CORDIC_STAGES].h;
    {trig_d.st, trig_d.ct}  = fold(st_q[e2c_pkg::CORDIC_STAGES].vt,
                                   st_q[e2c_pkg::CORDIC_STAGES].qt);
    {trig_d.sp, trig_d.cp}  = fold(st_q[e2c_pkg::CORDIC_STAGES].vp,
                                   st_q[e2c_pkg::CORDIC_STAGES].qp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vm_q <= 1'b0;
    end else if (en_i) begin
      v_q  <= {v_q[e2c_pkg::CORDIC_STAGES-1:0], valid_i};
      vm_q <= v_q[e2c_pkg::CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= seed;
      for (int s = 1; s <= e2c_pkg::CORDIC_STAGES; s++) begin
        st_q[s] <= st_d[s];
      end
      trig_q <= trig_d;
    end
  end

  assign valid_o = vm_q;
  assign trig_o  = trig_q;

endmodule

// File: sv/e2c_face_sel.sv
// Direction magnitudes, cube face choice and face numerators H*(m +/- c).
// Three register stages. Depends on e2c_pkg.
module e2c_face_sel (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  e2c_pkg::trig_t  trig_i,
  output logic            valid_o,
  output e2c_pkg::ratio_t ratio_o
);

  // stage A: magnitudes
  logic [e2c_pkg::H_W-1:0]  ha_q;
  logic [e2c_pkg::AX_W-1:0] ax_q, ay_q, az_q;
  logic                     nx_q, ny_q, nz_q;
  logic [e2c_pkg::AX_W-1:0] ax_d, ay_d, az_d;
  // stage B: face and clamped numerators
  logic [e2c_pkg::H_W-1:0]    hb_q;
  logic [e2c_pkg::FACE_W-1:0] face_q, face_d;
  logic [e2c_pkg::AX_W-1:0]   m_q, m_d;
  logic [e2c_pkg::AB_W-1:0]   a_q, b_q, a_d, b_d;
  // stage C
  e2c_pkg::ratio_t          ratio_q;
  logic [2:0]               v_q;

  always_comb begin
    logic [e2c_pkg::MAG_W-1:0]  mct, mst, msp;
    logic [e2c_pkg::PROD_W-1:0] px, py;
    mct  = e2c_pkg::mag(trig_i.ct);
    mst  = e2c_pkg::mag(trig_i.st);
    msp  = e2c_pkg::mag(trig_i.sp);
    px   = mct * msp;
    py   = mst * msp;
    ax_d = px[e2c_pkg::PROD_W-1:e2c_pkg::FRAC_BITS];
    ay_d = py[e2c_pkg::PROD_W-1:e2c_pkg::FRAC_BITS];
    az_d = e2c_pkg::AX_W'(e2c_pkg::mag(trig_i.cp));
  end

  always_comb begin
    logic                               ex, ey;
    logic signed [e2c_pkg::SAB_W-1:0]   sx, sy, sz, mm, a, b;
    // a zero magnitude counts as positive
    ex = nx_q && (ax_q != '0);
    ey = ny_q && (ay_q != '0);
    sx = ex ? -e2c_pkg::SAB_W'(ax_q) : e2c_pkg::SAB_W'(ax_q);
    sy = ey ? -e2c_pkg::SAB_W'(ay_q) : e2c_pkg::SAB_W'(ay_q);
    sz = nz_q ? -e2c_pkg::SAB_W'(az_q) : e2c_pkg::SAB_W'(az_q);
    if (ax_q >= ay_q && ax_q >= az_q) begin
      m_d    = ax_q;
      face_d = ex ? e2c_pkg::FACE_XN : e2c_pkg::FACE_XP;
      mm     = e2c_pkg::SAB_W'(ax_q);
      a      = ex ? mm - sy : mm + sy;
      b      = mm - sz;
    end else if (ay_q >= az_q) begin
      m_d    = ay_q;
      face_d = ey ? e2c_pkg::FACE_YP : e2c_pkg::FACE_YN;
      mm     = e2c_pkg::SAB_W'(ay_q);
      a      = ey ? mm + sx : mm - sx;
      b      = mm - sz;
    end else begin
      m_d    = az_q;
      face_d = nz_q ? e2c_pkg::FACE_ZN : e2c_pkg::FACE_ZP;
      mm     = e2c_pkg::SAB_W'(az_q);
      a      = mm + sy;
      b      = nz_q ? mm - sx : mm + sx;
    end
    a_d = a[e2c_pkg::SAB_W-1] ? '0 : a[e2c_pkg::AB_W-1:0];
    b_d = b[e2c_pkg::SAB_W-1] ? '0 : b[e2c_pkg::AB_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ha_q <= trig_i.h;
      ax_q <= ax_d;
      ay_q <= ay_d;
      az_q <= az_d;
      nx_q <= trig_i.ct[e2c_pkg::TRIG_W-1] ^ trig_i.sp[e2c_pkg::TRIG_W-1];
      ny_q <= trig_i.st[e2c_pkg::TRIG_W-1] ^ trig_i.sp[e2c_pkg::TRIG_W-1];
      nz_q <= trig_i.cp[e2c_pkg::TRIG_W-1];

      hb_q   <= ha_q;
      face_q <= face_d;
      m_q    <= m_d;
      a_q    <= a_d;
      b_q    <= b_d;

      ratio_q.h    <= hb_q;
      ratio_q.face <= face_q;
      ratio_q.zero <= (m_q == '0);
      ratio_q.nx   <= hb_q * a_q;
      ratio_q.ny   <= hb_q * b_q;
      ratio_q.den  <= {m_q, 1'b0};
    end
  end

  assign valid_o = v_q[2];
  assign ratio_o = ratio_q;

endmodule

// File: sv/e2c_ratio_div.sv
// Pipelined restoring divider for face_x and face_y, two quotient bits per
// stage, plus the result register. Depends on e2c_pkg.
module e2c_ratio_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  e2c_pkg::ratio_t ratio_i,
  output logic            valid_o,
  output e2c_pkg::res_t   res_o
);

  typedef struct packed {
    logic [e2c_pkg::H_W-1:0]    h;
    logic [e2c_pkg::FACE_W-1:0] face;
    logic                       zero;
    logic [e2c_pkg::DEN_W-1:0]  den;
    logic [e2c_pkg::Q_W-1:0]    lx;
    logic [e2c_pkg::Q_W-1:0]    ly;
    logic [e2c_pkg::REM_W-1:0]  rx;
    logic [e2c_pkg::REM_W-1:0]  ry;
    logic [e2c_pkg::Q_W-1:0]    qx;
    logic [e2c_pkg::Q_W-1:0]    qy;
  } rstage_t;

  rstage_t                       seed;
  rstage_t                       st_q [0:e2c_pkg::RAT_STAGES];
  rstage_t                       st_d [1:e2c_pkg::RAT_STAGES];
  logic [e2c_pkg::RAT_STAGES:0]  v_q;
  e2c_pkg::res_t                 res_d, res_q;
  logic                          vr_q;

  function automatic logic [e2c_pkg::REM_W:0] div_step(
    logic [e2c_pkg::REM_W-1:0] r, logic [e2c_pkg::DEN_W-1:0] d, logic b);
    logic [e2c_pkg::REM_W:0] sh;
    sh = {r, b};
    if (sh >= {1'b0, d}) begin
      return {1'b1, e2c_pkg::REM_W'(sh - {1'b0, d})};
    end
    return {1'b0, sh[e2c_pkg::REM_W-1:0]};
  endfunction

  // quotient never exceeds H, so the top numerator bits already sit below den
  always_comb begin
    seed.h    = ratio_i.h;
    seed.face = ratio_i.face;
    seed.zero = ratio_i.zero;
    seed.den  = ratio_i.den;
    seed.lx   = ratio_i.nx[e2c_pkg::Q_W-1:0];
    seed.ly   = ratio_i.ny[e2c_pkg::Q_W-1:0];
    seed.rx   = ratio_i.nx[e2c_pkg::NUM_W-1:e2c_pkg::Q_W];
    seed.ry   = ratio_i.ny[e2c_pkg::NUM_W-1:e2c_pkg::Q_W];
    seed.qx   = '0;
    seed.qy   = '0;
  end

  always_comb begin
    logic [e2c_pkg::REM_W:0] sx, sy;
    int                      k;
    for (int s = 1; s <= e2c_pkg::RAT_STAGES; s++) begin
      st_d[s] = st_q[s-1];
      for (int j = 0; j < e2c_pkg::RAT_PER_STAGE; j++) begin
        k  = e2c_pkg::Q_W - 1 - ((s - 1) * e2c_pkg::RAT_PER_STAGE + j);
        sx = div_step(st_d[s].rx, st_d[s].den, st_d[s].lx[k]);
        sy = div_step(st_d[s].ry, st_d[s].den, st_d[s].ly[k]);
        st_d[s].rx = sx[e2c_pkg::REM_W-1:0];
        st_d[s].ry = sy[e2c_pkg::REM_W-1:0];
        st_d[s].qx = {st_d[s].qx[e2c_pkg::Q_W-2:0], sx[e2c_pkg::REM_W]};
        st_d[s].qy = {st_d[s].qy[e2c_pkg::Q_W-2:0], sy[e2c_pkg::REM_W]};
      end
    end
  end

  // zero direction: face X+, both indices at the face center
  always_comb begin
    if (st_q[e2c_pkg::RAT_STAGES].zero) begin
      res_d.face = e2c_pkg::FACE_XP;
      res_d.fx   = st_q[e2c_pkg::RAT_STAGES].h >> 1;
      res_d.fy   = st_q[e2c_pkg::RAT_STAGES].h >> 1;
    end else begin
      res_d.face = st_q[e2c_pkg::RAT_STAGES].face;
      res_d.fx   = e2c_pkg::H_W'(st_q[e2c_pkg::RAT_STAGES].qx);
      res_d.fy   = e2c_pkg::H_W'(st_q[e2c_pkg::RAT_STAGES].qy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vr_q <= 1'b0;
    end else if (en_i) begin
      v_q  <= {v_q[e2c_pkg::RAT_STAGES-1:0], valid_i};
      vr_q <= v_q[e2c_pkg::RAT_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= seed;
      for (int s = 1; s <= e2c_pkg::RAT_STAGES; s++) begin
        st_q[s] <= st_d[s];
      end
      res_q <= res_d;
    end
  end

  assign valid_o = vr_q;
  assign res_o   = res_q;

endmodule

// File: sv/equirect_to_cubemap_lookup.sv
// Top level of the equirectangular to cubemap lookup: config register,
// pipeline chain and output register with skid. Depends on e2c_pkg and the
// e2c_angle_div, e2c_cordic, e2c_face_sel and e2c_ratio_div modules.

// Takes one pixel (row, col) per clock while in_stall_o is low and returns
// its cube face and face coordinates. Throughput is one pixel per clock
// while in_stall_o is low. The pipe is made of the 32-step angle divider
// (input register plus 16 stages), the 20-iteration CORDIC (input
// register, 10 stages and fold-out), three face stages, the 12-step ratio
// divider (input register, 6 stages and result register) and the output
// register. A skid entry behind the output register takes a result when
// the output first stalls, so the pipe can keep moving; in_stall_o rises
// only once that entry is full. out_height is sampled per pixel at input,
// clamped to 2..2048, and should be written only while the pipe is empty.
module equirect_to_cubemap_lookup (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [e2c_pkg::H_W-1:0]          cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [e2c_pkg::ROW_W-1:0]        row_i,
  input  logic [e2c_pkg::COL_W-1:0]        col_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [e2c_pkg::FACE_W-1:0]       face_o,
  output logic [e2c_pkg::H_W-1:0]          face_x_o,
  output logic [e2c_pkg::H_W-1:0]          face_y_o
);

  logic [e2c_pkg::H_W-1:0] h_q;
  logic [e2c_pkg::H_W-1:0] h_clamp;
  logic                    en;
  logic                    ang_v, trig_v, ratio_v, pipe_v;
  e2c_pkg::ang_t           ang;
  e2c_pkg::trig_t          trig;
  e2c_pkg::ratio_t         ratio;
  e2c_pkg::res_t           pipe_res;
  e2c_pkg::res_t           out_q, skid_q;
  logic                    out_v_q, skid_v_q;
  logic                    out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= e2c_pkg::H_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      h_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (h_q < e2c_pkg::H_MIN) begin
      h_clamp = e2c_pkg::H_MIN;
    end else if (h_q > e2c_pkg::H_MAX) begin
      h_clamp = e2c_pkg::H_MAX;
    end else begin
      h_clamp = h_q;
    end
  end

  // the whole pipe advances while the skid entry is free
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  e2c_angle_div u_angle_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .h_i     (h_clamp),
    .row_i   (row_i),
    .col_i   (col_i),
    .valid_o (ang_v),
    .ang_o   (ang)
  );

  e2c_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ang_v),
    .ang_i   (ang),
    .valid_o (trig_v),
    .trig_o  (trig)
  );

  e2c_face_sel u_face_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (trig_v),
    .trig_i  (trig),
    .valid_o (ratio_v),
    .ratio_o (ratio)
  );

  e2c_ratio_div u_ratio_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ratio_v),
    .ratio_i (ratio),
    .valid_o (pipe_v),
    .res_o   (pipe_res)
  );

  assign out_free = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= pipe_v;
      end
    end else if (!skid_v_q && pipe_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : pipe_res;
    end else if (!skid_v_q) begin
      skid_q <= pipe_res;
    end
  end

  assign out_valid_o = out_v_q;
  assign face_o      = out_q.face;
  assign face_x_o    = out_q.fx;
  assign face_y_o    = out_q.fy;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held while output register empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid entry filled without an output stall");

  a_face_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.face <= e2c_pkg::FACE_ZN))
    else $error("face code out of range");

  a_face_coord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.fx <= e2c_pkg::H_MAX && out_q.fy <= e2c_pkg::H_MAX))
    else $error("face coordinate above maximum height");

endmodule
